// ===== design/ir_pwcd_pkg.sv =====
// Shared types, register indexes and reset constants for the IR pulse-width decoder.
package ir_pwcd_pkg;

    localparam int unsigned WORD_BITS_DEF = 16;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned HELD_W     = 4;
    localparam int unsigned CMD_OUT_W  = 16;

    localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd5;
    localparam logic [CFG_W-1:0] BIT_SPLIT_RST   = 16'd15;
    localparam logic [CFG_W-1:0] LONG_LIMIT_RST  = 16'd30;
    localparam logic [CFG_W-1:0] KEY_FWD_RST     = 16'b0010010001010111;
    localparam logic [CFG_W-1:0] KEY_REW_RST     = 16'b0010110001010111;
    localparam logic [CFG_W-1:0] PLAY_KEY_RST    = 16'b0000010001010111;
    localparam logic [CFG_W-1:0] STOP_KEY_RST    = 16'b0001010001010111;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_LIMIT = 3'd0,
        CFG_BIT_SPLIT   = 3'd1,
        CFG_LONG_LIMIT  = 3'd2,
        CFG_KEY_FWD     = 3'd3,
        CFG_KEY_REW     = 3'd4,
        CFG_PLAY_KEY    = 3'd5,
        CFG_STOP_KEY    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_LONG  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_ZERO  = 2'd2,
        KIND_SHORT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_FORWARD = 3'd1,
        ACT_REWIND  = 3'd2,
        ACT_PLAY    = 3'd3,
        ACT_STOP    = 3'd4
    } t_action;

    typedef struct packed {
        logic [CFG_W-1:0] short_limit;
        logic [CFG_W-1:0] bit_split;
        logic [CFG_W-1:0] long_limit;
        logic [CFG_W-1:0] key_fwd;
        logic [CFG_W-1:0] key_rew;
        logic [CFG_W-1:0] play_key;
        logic [CFG_W-1:0] stop_key;
    } t_cfg;

    typedef struct packed {
        t_kind                kind;
        logic [HELD_W-1:0]    bits_held;
        logic                 new_command;
        logic [CMD_OUT_W-1:0] command_word;
        t_action              action;
    } t_result;

endpackage

// ===== design/ir_pwcd_cfg.sv =====
// Configuration register file: thresholds and key codes.
module ir_pwcd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [ir_pwcd_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [ir_pwcd_pkg::CFG_W-1:0]       i_data,
    output ir_pwcd_pkg::t_cfg                   o_cfg
);
    import ir_pwcd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_SHORT_LIMIT: n_cfg.short_limit = i_data;
                CFG_BIT_SPLIT:   n_cfg.bit_split   = i_data;
                CFG_LONG_LIMIT:  n_cfg.long_limit  = i_data;
                CFG_KEY_FWD:     n_cfg.key_fwd     = i_data;
                CFG_KEY_REW:     n_cfg.key_rew     = i_data;
                CFG_PLAY_KEY:    n_cfg.play_key    = i_data;
                CFG_STOP_KEY:    n_cfg.stop_key    = i_data;
                default:         n_cfg = r_cfg;   // unused index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_limit <= SHORT_LIMIT_RST;
            r_cfg.bit_split   <= BIT_SPLIT_RST;
            r_cfg.long_limit  <= LONG_LIMIT_RST;
            r_cfg.key_fwd     <= KEY_FWD_RST;
            r_cfg.key_rew     <= KEY_REW_RST;
            r_cfg.play_key    <= PLAY_KEY_RST;
            r_cfg.stop_key    <= STOP_KEY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/ir_pwcd_decode.sv =====
// Interval classification, bit assembly, command latch and key match.
module ir_pwcd_decode #(
    parameter int unsigned WORD_BITS = ir_pwcd_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [ir_pwcd_pkg::TIME_W-1:0]    i_edge_time,
    input  ir_pwcd_pkg::t_cfg                 i_cfg,
    output ir_pwcd_pkg::t_result              o_res
);
    import ir_pwcd_pkg::*;

    localparam int unsigned POS_W = $clog2(WORD_BITS + 1);
    localparam int unsigned CMP_W = (WORD_BITS > CFG_W) ? WORD_BITS : CFG_W;
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(WORD_BITS);

    logic [TIME_W-1:0]    r_last_edge;
    logic [WORD_BITS-1:0] r_word;
    logic [POS_W-1:0]     r_pos;
    logic [WORD_BITS-1:0] r_latched;
    t_result              r_res;

    logic [TIME_W-1:0]    gap;
    t_kind                kind;
    logic [WORD_BITS-1:0] n_word;
    logic [POS_W-1:0]     n_pos;
    logic [WORD_BITS-1:0] n_latched;
    logic                 n_done;
    logic [CMP_W-1:0]     cmd_ext;
    t_action              n_action;

    assign gap = i_edge_time - r_last_edge;

    // tests run in fixed order, so out-of-order limits just hide classes
    always_comb begin
        if (gap <= i_cfg.short_limit) begin
            kind = KIND_SHORT;
        end else if (gap <= i_cfg.bit_split) begin
            kind = KIND_ZERO;
        end else if (gap <= i_cfg.long_limit) begin
            kind = KIND_ONE;
        end else begin
            kind = KIND_LONG;
        end
    end

    always_comb begin
        n_word    = r_word;
        n_pos     = r_pos;
        n_latched = r_latched;
        n_done    = 1'b0;
        case (kind)
            KIND_LONG: begin
                n_word = '0;
                n_pos  = '0;
            end
            KIND_ONE: begin
                n_word = r_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << r_pos);
                n_pos  = r_pos + 1'b1;
            end
            KIND_ZERO: begin
                n_pos  = r_pos + 1'b1;
            end
            default: ;
        endcase
        if (n_pos == POS_FULL) begin
            n_latched = n_word;
            n_word    = '0;
            n_pos     = '0;
            n_done    = 1'b1;
        end
    end

    // first match wins: forward, rewind, play, stop
    always_comb begin
        cmd_ext = CMP_W'(n_latched);
        if (cmd_ext == CMP_W'(i_cfg.key_fwd)) begin
            n_action = ACT_FORWARD;
        end else if (cmd_ext == CMP_W'(i_cfg.key_rew)) begin
            n_action = ACT_REWIND;
        end else if (cmd_ext == CMP_W'(i_cfg.play_key)) begin
            n_action = ACT_PLAY;
        end else if (cmd_ext == CMP_W'(i_cfg.stop_key)) begin
            n_action = ACT_STOP;
        end else begin
            n_action = ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_word      <= '0;
            r_pos       <= '0;
            r_latched   <= '0;
        end else if (i_step) begin
            r_last_edge <= i_edge_time;
            r_word      <= n_word;
            r_pos       <= n_pos;
            r_latched   <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res.kind         <= kind;
            r_res.bits_held    <= HELD_W'(n_pos);
            r_res.new_command  <= n_done;
            r_res.command_word <= CMD_OUT_W'(n_latched);
            r_res.action       <= n_action;
        end
    end

    assign o_res = r_res;

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && n_done |=> r_res.bits_held == '0 && r_pos == '0)
        else $error("completed command left bits in the partial word");

    a_long_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && kind == KIND_LONG |=> r_pos == '0 && !r_res.new_command)
        else $error("long interval did not clear the partial word");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_FULL)
        else $error("bit position reached the word length");

endmodule

// ===== design/ir_pulse_width_command_decoder.sv =====
// Top level of the IR pulse-width command decoder: handshakes and pipeline control.
//
//  Channel   Direction  Handshake              Payload
//  in        to block   i_in_valid/o_in_stall   i_edge_time
//  out       from block o_out_valid/i_out_stall o_pulse_kind, o_bits_held, o_new_command,
//                                              o_command_word, o_action
//  cfg       to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while the output does not stall; the result is
//  registered after the input accept edge (input register, then the decode logic
//  into the result register). Rate is set by the state update in the decode stage.
//  Reset is synchronous and active low: thresholds and key codes return to their
//  defaults, decode state and both valid flags clear.
//  A stall on the output holds the result register; the input register still takes
//  one request, and o_in_stall rises only when both stages are full.
//  Configuration is always ready and takes effect on the next cycle.
module ir_pulse_width_command_decoder #(
    parameter int unsigned WORD_BITS = ir_pwcd_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input requests
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ir_pwcd_pkg::TIME_W-1:0]      i_edge_time,
    // result requests
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_pulse_kind,
    output logic [ir_pwcd_pkg::HELD_W-1:0]      o_bits_held,
    output logic                                o_new_command,
    output logic [ir_pwcd_pkg::CMD_OUT_W-1:0]   o_command_word,
    output logic [2:0]                          o_action,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ir_pwcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ir_pwcd_pkg::CFG_W-1:0]       i_cfg_data
);
    import ir_pwcd_pkg::*;

    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;

    logic    out_free;   // result register empty or being drained
    logic    step;       // input register moves into the decode stage
    logic    in_accept;
    t_cfg    cfg;
    t_result res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // input register: refills in the same cycle it empties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_time <= i_edge_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    ir_pwcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ir_pwcd_decode #(
        .WORD_BITS (WORD_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_edge_time (r_in_time),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    assign o_out_valid    = r_out_valid;
    assign o_pulse_kind   = res.kind;
    assign o_bits_held    = res.bits_held;
    assign o_new_command  = res.new_command;
    assign o_command_word = res.command_word;
    assign o_action       = res.action;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled while a stage was free");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("decoded request lost before the result register");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !step)
        else $error("decode stage overwrote a stalled result");

endmodule
